@@ hdl/tcld_pkg.sv @@
// ----------------------------------------------------------------------------
// tcld_pkg: shared types and text tables of the command line decoder
// Holds the controller/datapath command and status groups, the keyword
// and response text tables and the pin level group.
// ----------------------------------------------------------------------------
package tcld_pkg;

	localparam int NUM_KEYS    = 9;
	localparam int KEY_IDX_W   = 4;
	localparam int KEY_POS_W   = 6;
	localparam int KEY_LEN_W   = 4;
	localparam int REPLY_POS_W = 5;
	localparam int KEY_TXT_W   = 80;
	localparam int REPLY_TXT_W = 136;

	localparam logic [7:0] CR_BYTE = 8'd13;

	// Response indexes: one per keyword, then the invalid answer.
	localparam logic [KEY_IDX_W-1:0] KEY_LED1_OFF   = 4'd0;
	localparam logic [KEY_IDX_W-1:0] KEY_LED1_ON    = 4'd1;
	localparam logic [KEY_IDX_W-1:0] KEY_LED2_OFF   = 4'd2;
	localparam logic [KEY_IDX_W-1:0] KEY_LED2_ON    = 4'd3;
	localparam logic [KEY_IDX_W-1:0] KEY_BUZZER_ON  = 4'd4;
	localparam logic [KEY_IDX_W-1:0] KEY_BUZZER_OFF = 4'd5;
	localparam logic [KEY_IDX_W-1:0] KEY_MOTOR_ON   = 4'd6;
	localparam logic [KEY_IDX_W-1:0] KEY_MOTOR_OFF  = 4'd7;
	localparam logic [KEY_IDX_W-1:0] KEY_STATUS     = 4'd8;
	localparam logic [KEY_IDX_W-1:0] RPL_INVALID    = 4'd9;

	// Pin levels; led1 sits in the lowest bit.
	typedef struct packed {
		logic motor;
		logic buzzer;
		logic led2;
		logic led1;
	} pins_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;
		logic start_scan;
		logic scan;
		logic apply;
		logic emit_load;
	} tcld_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_cr;
		logic scan_done;
		logic emit_last;
		logic out_free;
	} tcld_status_t;

	function automatic logic [KEY_TXT_W-1:0] key_text(input logic [KEY_IDX_W-1:0] idx);
		logic [KEY_TXT_W-1:0] t;
		case (idx)
			KEY_LED1_OFF:   t = "LED1 OFF";
			KEY_LED1_ON:    t = "LED1 ON";
			KEY_LED2_OFF:   t = "LED2 OFF";
			KEY_LED2_ON:    t = "LED2 ON";
			KEY_BUZZER_ON:  t = "BUZZER ON";
			KEY_BUZZER_OFF: t = "BUZZER OFF";
			KEY_MOTOR_ON:   t = "MOTOR ON";
			KEY_MOTOR_OFF:  t = "MOTOR OFF";
			KEY_STATUS:     t = "STATUS";
			default:        t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [KEY_LEN_W-1:0] key_len(input logic [KEY_IDX_W-1:0] idx);
		logic [KEY_LEN_W-1:0] n;
		case (idx)
			KEY_LED1_OFF:   n = 4'd8;
			KEY_LED1_ON:    n = 4'd7;
			KEY_LED2_OFF:   n = 4'd8;
			KEY_LED2_ON:    n = 4'd7;
			KEY_BUZZER_ON:  n = 4'd9;
			KEY_BUZZER_OFF: n = 4'd10;
			KEY_MOTOR_ON:   n = 4'd8;
			KEY_MOTOR_OFF:  n = 4'd9;
			KEY_STATUS:     n = 4'd6;
			default:        n = 4'd0;
		endcase
		return n;
	endfunction

	// Character at position pos (from the first character) of a keyword.
	function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx,
			input logic [KEY_POS_W-1:0] pos);
		logic [KEY_TXT_W-1:0] t;
		int n;
		t = key_text(idx);
		n = int'(key_len(idx));
		if (int'(pos) < n) begin
			return t[8*(n-1-int'(pos)) +: 8];
		end
		return 8'd0;
	endfunction

	function automatic logic [REPLY_TXT_W-1:0] reply_text(input logic [KEY_IDX_W-1:0] idx);
		logic [REPLY_TXT_W-1:0] t;
		case (idx)
			KEY_LED1_OFF:   t = "LED1 OFF\r\n";
			KEY_LED1_ON:    t = "LED1 ON\r\n";
			KEY_LED2_OFF:   t = "LED2 OFF\r\n";
			KEY_LED2_ON:    t = "LED2 ON\r\n";
			KEY_BUZZER_ON:  t = "BUZZER ON\r\n";
			KEY_BUZZER_OFF: t = "BUZZER OFF\r\n";
			KEY_MOTOR_ON:   t = "MOTOR ON\r\n";
			KEY_MOTOR_OFF:  t = "MOTOR OFF\r\n";
			KEY_STATUS:     t = "SYSTEM OK\r\n";
			default:        t = "INVALID COMMAND\r\n";
		endcase
		return t;
	endfunction

	function automatic logic [REPLY_POS_W-1:0] reply_len(input logic [KEY_IDX_W-1:0] idx);
		logic [REPLY_POS_W-1:0] n;
		if (idx == KEY_STATUS) begin
			n = 5'd11;
		end else if (idx < KEY_STATUS) begin
			n = REPLY_POS_W'(key_len(idx)) + 5'd2;
		end else begin
			n = 5'd17;
		end
		return n;
	endfunction

	function automatic logic [7:0] reply_char(input logic [KEY_IDX_W-1:0] idx,
			input logic [REPLY_POS_W-1:0] pos);
		logic [REPLY_TXT_W-1:0] t;
		int n;
		t = reply_text(idx);
		n = int'(reply_len(idx));
		if (int'(pos) < n) begin
			return t[8*(n-1-int'(pos)) +: 8];
		end
		return 8'd0;
	endfunction

endpackage

@@ hdl/text_command_line_decoder_unit.sv @@
// A non-CR word is taken while idle and the block stays ready for the next word.
// A carriage return scans the stored line one character a cycle through the line
// memory read port, then applies the match in the apply state.
// Throughput: one response character per cycle from the output register, up to 17,
// as long as the receiver does not stall the output.
// Reset: arst_n clears the line length, overflow flag, pin levels and the controller;
// the line memory is not cleared.
// ----------------------------------------------------------------------------
// text_command_line_decoder_unit: serial text command decoder
// Gathers received characters into a line, matches a finished line against
// the fixed keywords, drives four pin levels and streams the response text.
// ----------------------------------------------------------------------------
module text_command_line_decoder_unit #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] tx_char, [8] led1_level, [9] led2_level,
	                               // [10] buzzer_level, [11] motor_level, [15:12] zero
	output logic        m_tlast    // last_char
);
	import tcld_pkg::*;

	tcld_cmd_t    cmd;
	tcld_status_t status;
	logic [7:0]   out_char;
	pins_t        out_pins;

	tcld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	tcld_datapath #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast),
		.out_pins  (out_pins)
	);

	// Pack the output word.
	assign m_tdata = {4'b0000, out_pins, out_char};

`ifndef SYNTHESIS
	// A carriage return makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tdata == CR_BYTE)) |=> !s_tready)
		else $error("block still ready after a carriage return");

	// While a response run is incomplete, no new word is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input taken in the middle of a response");

	// Pin levels do not change between characters of one response.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> !m_tvalid
			|| (m_tdata[11:8] == $past(m_tdata[11:8])))
		else $error("pin levels changed within a response");
`endif

endmodule

@@ hdl/tcld_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcld_ctrl: sequencing state machine of the command line decoder
// Takes words while idle, runs the buffer scan on a carriage return,
// applies the result and then streams the response out.
// ----------------------------------------------------------------------------
module tcld_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tcld_pkg::tcld_status_t status,
	output logic                  in_ready,
	output tcld_pkg::tcld_cmd_t    cmd
);
	import tcld_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_take;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;

	// Commands follow directly from the state and the handshakes.
	always_comb begin
		cmd            = '0;
		cmd.store      = in_take && !status.in_is_cr;
		cmd.start_scan = in_take && status.in_is_cr;
		cmd.scan       = (state_q == ST_SCAN);
		cmd.apply      = (state_q == ST_APPLY);
		cmd.emit_load  = (state_q == ST_EMIT) && status.out_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && status.in_is_cr) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/tcld_datapath.sv @@
// ----------------------------------------------------------------------------
// tcld_datapath: line buffer, keyword matcher and response generator
// Stores line characters in a memory, reads them back one a cycle to
// narrow a keyword candidate mask, keeps the pin levels and fills the
// output register with response characters.
// ----------------------------------------------------------------------------
module tcld_datapath #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             rx_byte,
	input  tcld_pkg::tcld_cmd_t     cmd,
	output tcld_pkg::tcld_status_t  status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_char,
	output logic                   out_last,
	output tcld_pkg::pins_t         out_pins
);
	import tcld_pkg::*;

	localparam int LW = $clog2(LINE_CAPACITY + 1);
	localparam int AW = $clog2(LINE_CAPACITY);

	logic [7:0]             line_mem [LINE_CAPACITY];
	logic [LW-1:0]          line_len_q;
	logic                   overflow_q;
	logic [LW-1:0]          scan_idx_q;
	logic                   rd_vld_q;
	logic [AW-1:0]          rd_pos_q;
	logic [7:0]             rd_data_q;
	logic [NUM_KEYS-1:0]    mask_q;
	logic [NUM_KEYS-1:0]    mask_init;
	logic [NUM_KEYS-1:0]    mask_next;
	logic [KEY_IDX_W-1:0]   hit_idx;
	logic [KEY_IDX_W-1:0]   reply_q;
	logic [REPLY_POS_W-1:0] emit_cnt_q;
	pins_t                  pins_q;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;
	pins_t                  out_pins_q;
	logic                   scan_rd;

	assign scan_rd = cmd.scan && (scan_idx_q < line_len_q);

	// Line memory: written while collecting, read once a cycle during the scan.
	always_ff @(posedge clk) begin
		if (cmd.store && (line_len_q < LW'(LINE_CAPACITY))) begin
			line_mem[line_len_q[AW-1:0]] <= rx_byte;
		end
		if (scan_rd) begin
			rd_data_q <= line_mem[scan_idx_q[AW-1:0]];
			rd_pos_q  <= scan_idx_q[AW-1:0];
		end
	end

	// Candidates at scan start: keywords of the line's length, none on overflow.
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			mask_init[k] = !overflow_q
				&& (LW'(key_len(KEY_IDX_W'(k))) == line_len_q);
		end
	end

	// Drop every candidate whose character differs at the position just read.
	always_comb begin
		mask_next = mask_q;
		if (rd_vld_q) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (key_char(KEY_IDX_W'(k), KEY_POS_W'(rd_pos_q)) != rd_data_q) begin
					mask_next[k] = 1'b0;
				end
			end
		end
	end

	// First remaining candidate, or the invalid answer.
	always_comb begin
		hit_idx = RPL_INVALID;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				hit_idx = KEY_IDX_W'(k);
			end
		end
	end

	// Line collection, scan sequencing, pin update and response count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			overflow_q <= 1'b0;
			scan_idx_q <= '0;
			rd_vld_q   <= 1'b0;
			mask_q     <= '0;
			reply_q    <= RPL_INVALID;
			emit_cnt_q <= '0;
			pins_q     <= '0;
		end else begin
			if (cmd.store) begin
				if (line_len_q < LW'(LINE_CAPACITY)) begin
					line_len_q <= line_len_q + 1'b1;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.start_scan) begin
				scan_idx_q <= '0;
				rd_vld_q   <= 1'b0;
				mask_q     <= mask_init;
			end
			if (cmd.scan) begin
				rd_vld_q <= scan_rd;
				mask_q   <= mask_next;
				if (scan_rd) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			if (cmd.apply) begin
				reply_q    <= hit_idx;
				emit_cnt_q <= '0;
				line_len_q <= '0;
				overflow_q <= 1'b0;
				case (hit_idx)
					KEY_LED1_OFF:   pins_q.led1   <= 1'b0;
					KEY_LED1_ON:    pins_q.led1   <= 1'b1;
					KEY_LED2_OFF:   pins_q.led2   <= 1'b0;
					KEY_LED2_ON:    pins_q.led2   <= 1'b1;
					KEY_BUZZER_ON:  pins_q.buzzer <= 1'b1;
					KEY_BUZZER_OFF: pins_q.buzzer <= 1'b0;
					KEY_MOTOR_ON:   pins_q.motor  <= 1'b1;
					KEY_MOTOR_OFF:  pins_q.motor  <= 1'b0;
					default:        pins_q        <= pins_q;
				endcase
			end
			if (cmd.emit_load) begin
				emit_cnt_q <= emit_cnt_q + 1'b1;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_char_q <= reply_char(reply_q, emit_cnt_q);
			out_last_q <= status.emit_last;
			out_pins_q <= pins_q;
		end
	end

	always_comb begin
		status           = '0;
		status.in_is_cr  = (rx_byte == CR_BYTE);
		status.scan_done = (scan_idx_q == line_len_q) && !rd_vld_q;
		status.emit_last = (emit_cnt_q == reply_len(reply_q) - 1'b1);
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_pins  = out_pins_q;

endmodule

@@ dv/tcld_response_checker.sv @@
// ----------------------------------------------------------------------------
// tcld_response_checker: response predictor and scoreboard
// Watches both stream channels of the command line decoder, keeps its own
// copy of the line buffer and pin levels, predicts the response words of
// every finished line and compares each output word with the oldest one.
// ----------------------------------------------------------------------------
module tcld_response_checker #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] tx_char, [11:8] pin levels, [15:12] zero
	input  logic        m_tlast,   // last_char
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tcld_pkg::*;

	// One predicted response word.
	typedef struct {
		logic [7:0] ch;
		logic       last;
		pins_t      pins;
	} tx_word_t;

	string      keyword_txt [NUM_KEYS];
	string      answer_txt  [NUM_KEYS+1];
	logic [7:0] line_buf    [LINE_CAPACITY];
	int         line_len;
	bit         line_over;
	pins_t      pin_state;
	tx_word_t   answer_q [$];

	// Keyword and response texts, indexed by the package's response codes.
	initial begin
		keyword_txt[KEY_LED1_OFF]   = "LED1 OFF";
		keyword_txt[KEY_LED1_ON]    = "LED1 ON";
		keyword_txt[KEY_LED2_OFF]   = "LED2 OFF";
		keyword_txt[KEY_LED2_ON]    = "LED2 ON";
		keyword_txt[KEY_BUZZER_ON]  = "BUZZER ON";
		keyword_txt[KEY_BUZZER_OFF] = "BUZZER OFF";
		keyword_txt[KEY_MOTOR_ON]   = "MOTOR ON";
		keyword_txt[KEY_MOTOR_OFF]  = "MOTOR OFF";
		keyword_txt[KEY_STATUS]     = "STATUS";
		answer_txt[KEY_LED1_OFF]    = "LED1 OFF\r\n";
		answer_txt[KEY_LED1_ON]     = "LED1 ON\r\n";
		answer_txt[KEY_LED2_OFF]    = "LED2 OFF\r\n";
		answer_txt[KEY_LED2_ON]     = "LED2 ON\r\n";
		answer_txt[KEY_BUZZER_ON]   = "BUZZER ON\r\n";
		answer_txt[KEY_BUZZER_OFF]  = "BUZZER OFF\r\n";
		answer_txt[KEY_MOTOR_ON]    = "MOTOR ON\r\n";
		answer_txt[KEY_MOTOR_OFF]   = "MOTOR OFF\r\n";
		answer_txt[KEY_STATUS]      = "SYSTEM OK\r\n";
		answer_txt[RPL_INVALID]     = "INVALID COMMAND\r\n";
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $realtime, what, got,
			want);
		fail_count++;
	endtask

	// Exact match of the stored line against one keyword, over its whole length.
	function automatic bit line_matches(input int k);
		string w;
		int    i;
		w = keyword_txt[k];
		if (w.len() != line_len) begin
			return 1'b0;
		end
		for (i = 0; i < line_len; i++) begin
			if (line_buf[i] != w[i]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// A carriage return: pick the answer, update the pins, queue the response words.
	task automatic finish_line();
		logic [KEY_IDX_W-1:0] sel;
		string                txt;
		tx_word_t             w;
		int                   k;
		sel = RPL_INVALID;
		if (!line_over) begin
			for (k = 0; k < NUM_KEYS && sel == RPL_INVALID; k++) begin
				if (line_matches(k)) begin
					sel = KEY_IDX_W'(k);
				end
			end
		end
		case (sel)
			KEY_LED1_OFF:   pin_state.led1 = 1'b0;
			KEY_LED1_ON:    pin_state.led1 = 1'b1;
			KEY_LED2_OFF:   pin_state.led2 = 1'b0;
			KEY_LED2_ON:    pin_state.led2 = 1'b1;
			KEY_BUZZER_ON:  pin_state.buzzer = 1'b1;
			KEY_BUZZER_OFF: pin_state.buzzer = 1'b0;
			KEY_MOTOR_ON:   pin_state.motor = 1'b1;
			KEY_MOTOR_OFF:  pin_state.motor = 1'b0;
			default: ;
		endcase
		txt = answer_txt[sel];
		for (k = 0; k < txt.len(); k++) begin
			w.ch   = txt[k];
			w.last = (k == txt.len() - 1);
			w.pins = pin_state;
			answer_q.push_back(w);
		end
		line_len  = 0;
		line_over = 1'b0;
	endtask

	// Bytes past the capacity are dropped and mark the line as too long.
	task automatic take_rx_byte(input logic [7:0] b);
		if (b == CR_BYTE) begin
			finish_line();
		end else if (line_len < LINE_CAPACITY) begin
			line_buf[line_len] = b;
			line_len++;
		end else begin
			line_over = 1'b1;
		end
	endtask

	task automatic check_tx_word();
		tx_word_t w;
		if (answer_q.size() == 0) begin
			report_mismatch("unexpected output word", m_tdata, 0);
		end else begin
			w = answer_q.pop_front();
			if (m_tdata[7:0] !== w.ch) begin
				report_mismatch("tx_char", m_tdata[7:0], w.ch);
			end
			if (m_tlast !== w.last) begin
				report_mismatch("last_char", m_tlast, w.last);
			end
			if (m_tdata[8] !== w.pins.led1) begin
				report_mismatch("led1_level", m_tdata[8], w.pins.led1);
			end
			if (m_tdata[9] !== w.pins.led2) begin
				report_mismatch("led2_level", m_tdata[9], w.pins.led2);
			end
			if (m_tdata[10] !== w.pins.buzzer) begin
				report_mismatch("buzzer_level", m_tdata[10], w.pins.buzzer);
			end
			if (m_tdata[11] !== w.pins.motor) begin
				report_mismatch("motor_level", m_tdata[11], w.pins.motor);
			end
			if (m_tdata[15:12] !== 4'd0) begin
				report_mismatch("tdata padding", m_tdata[15:12], 0);
			end
		end
	endtask

	// Output words are checked before the input word of the same edge is taken,
	// since a carriage return cannot answer in the cycle it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len   = 0;
			line_over  = 1'b0;
			pin_state  = '0;
			fail_count = 0;
			answer_q.delete();
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_tx_word();
			end
			if (s_tvalid && s_tready) begin
				take_rx_byte(s_tdata);
			end
			pending = answer_q.size();
		end
	end

endmodule

@@ dv/text_command_line_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_command_line_decoder_unit_tb: testbench top of the command line decoder
// Drives received characters in random bursts (a few directed lines, then
// mostly keywords with random damage, noise and overlong lines), stalls the
// response channel on a shifting pattern with one long hold, and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module text_command_line_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcld_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 9;
	localparam int LINE_CAP       = 32;
	localparam int ITEM_TARGET    = 270;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RX_HOLD_START  = 200;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int RUN_LIMIT_NS   = 5_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	int          burst_left;
	int          items_sent;

	text_command_line_decoder_unit #(
		.LINE_CAPACITY(LINE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	tcld_response_checker #(
		.LINE_CAPACITY(LINE_CAP)
	) response_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Receiver: shifting stall pattern in segments, some fully ready, and one long
	// hold so that the block backs up into its input.
	initial begin : rx_ready_gen
		int          cyc;
		int          seg_left;
		bit          steady;
		logic [15:0] pat;
		cyc      = 0;
		seg_left = 0;
		steady   = 1'b0;
		pat      = '0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == RX_HOLD_START) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end
			if (seg_left == 0) begin
				pat      = 16'($urandom);
				steady   = ($urandom_range(0, 3) == 0);
				seg_left = $urandom_range(16, 80);
			end
			seg_left--;
			m_tready <= steady | pat[0];
			pat = {pat[0], pat[15:1]};
		end
	end

	function automatic logic [7:0] any_but_cr();
		logic [7:0] b;
		do begin
			b = 8'($urandom);
		end while (b == CR_BYTE);
		return b;
	endfunction

	// Offers one word and waits for it to be taken; gaps fall between bursts.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_text(input string txt);
		int i;
		for (i = 0; i < txt.len(); i++) begin
			send_byte(txt[i]);
		end
	endtask

	initial begin : stimulus
		string      cmd_word [NUM_KEYS];
		string      word;
		logic [7:0] line_q [$];
		int         pick;
		int         n;
		int         i;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'd0;
		burst_left = 0;
		items_sent = 0;
		cmd_word[KEY_LED1_OFF]   = "LED1 OFF";
		cmd_word[KEY_LED1_ON]    = "LED1 ON";
		cmd_word[KEY_LED2_OFF]   = "LED2 OFF";
		cmd_word[KEY_LED2_ON]    = "LED2 ON";
		cmd_word[KEY_BUZZER_ON]  = "BUZZER ON";
		cmd_word[KEY_BUZZER_OFF] = "BUZZER OFF";
		cmd_word[KEY_MOTOR_ON]   = "MOTOR ON";
		cmd_word[KEY_MOTOR_OFF]  = "MOTOR OFF";
		cmd_word[KEY_STATUS]     = "STATUS";
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty line, extreme byte values, a keyword, a stray line feed.
		send_byte(CR_BYTE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CR_BYTE);
		send_text("LED1 ON");
		send_byte(CR_BYTE);
		send_byte(8'h0A);
		send_text("STATUS");
		send_byte(CR_BYTE);

		// Random lines, mostly well-formed keywords.
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			word = cmd_word[$urandom_range(0, NUM_KEYS - 1)];
			line_q.delete();
			if (pick >= 93) begin
				line_q.push_back(8'h0A);
			end
			if (pick < 73 || pick >= 85) begin
				for (i = 0; i < word.len(); i++) begin
					line_q.push_back(word[i]);
				end
			end
			if (pick >= 55 && pick < 65) begin
				// One character damaged.
				line_q[$urandom_range(0, line_q.size() - 1)] = any_but_cr();
			end else if (pick >= 65 && pick < 73) begin
				// One character too many or too few.
				if ($urandom_range(0, 1) == 1) begin
					line_q.push_back(any_but_cr());
				end else begin
					void'(line_q.pop_back());
				end
			end else if (pick >= 73 && pick < 85) begin
				// Noise, carriage returns included.
				n = $urandom_range(0, 10);
				for (i = 0; i < n; i++) begin
					line_q.push_back(8'($urandom));
				end
			end else if (pick >= 85 && pick < 93) begin
				// A keyword run on to around the line capacity and past it.
				n = $urandom_range(LINE_CAP - 2, LINE_CAP + 8);
				while (line_q.size() < n) begin
					line_q.push_back(any_but_cr());
				end
			end
			foreach (line_q[j]) begin
				send_byte(line_q[j]);
			end
			send_byte(CR_BYTE);
		end
		s_tvalid <= 1'b0;

		// Drain the responses, then watch a while for stray words.
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
